>>> rtl/core/sine_sum_plasma_pixel_generator_macros.svh
// Assertion macros for the plasma pixel generator checker.
// Needs a clk_i and an active-low rst_ni in the scope of each use.
`ifndef SINE_SUM_PLASMA_PIXEL_GENERATOR_MACROS_SVH
`define SINE_SUM_PLASMA_PIXEL_GENERATOR_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define SSP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("plasma generator check failed");

// Checks that an antecedent is followed in the next cycle by a consequent.
`define SSP_ASSERT_NEXT(label, pre, post) \
  `SSP_ASSERT(label, (pre) |=> (post))

`endif

>>> rtl/core/ssp_pkg.sv
// Shared types, constants, sine tables and palette for the plasma pixel generator.
// Depends on nothing; the top level, front, queue and back refer to it by scoped names.
package ssp_pkg;

  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int PHASE_W      = 9;
  localparam int SINE_W       = 12;
  localparam int SINE_ENTRIES = 512;
  localparam int HALF_ENTRIES = SINE_ENTRIES / 2;
  localparam int HALF_IDX_W   = $clog2(HALF_ENTRIES);
  localparam int QUEUE_DEPTH  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ENABLE = 2'd2;

  // Palette segments, selected by the top two bits of the index.
  localparam logic [1:0] PAL_RED_RISE   = 2'd0;
  localparam logic [1:0] PAL_GREEN_RISE = 2'd1;
  localparam logic [1:0] PAL_FADE       = 2'd2;
  localparam logic [1:0] PAL_GREEN_ONLY = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic             alpha_enable;
  } ssp_cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase_a;
    logic [PHASE_W-1:0] phase_b;
    logic [PHASE_W-1:0] phase_c;
    logic [PHASE_W-1:0] phase_d;
    logic               row_last;
    logic               frame_last;
    logic               alpha_enable;
  } ssp_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
  } ssp_colour_t;

  typedef logic signed [SINE_W-1:0] sine_half_t [HALF_ENTRIES];

  localparam longint unsigned ANGLE_DEN = 64'd64000000;
  localparam real             TWO_POW_60 = 2.0 ** 60;

  // Entry i is trunc(sin(r) * 1024), with r = i * 0.703125 * 0.0174532 rounded
  // to single precision. The angle is built exactly in Q60 and then rounded.
  function automatic logic signed [SINE_W-1:0] sine_entry(int unsigned i);
    longint unsigned num;
    longint unsigned r;
    longint unsigned rem;
    longint unsigned ulp;
    int              p;
    real             x;
    num = longint'(i) * 64'd785394;
    r   = (num / ANGLE_DEN) << 60;
    rem = num % ANGLE_DEN;
    for (int k = 0; k < 3; k++) begin
      rem = rem << 20;
      r   = r | ((rem / ANGLE_DEN) << (40 - 20 * k));
      rem = rem % ANGLE_DEN;
    end
    if (r == 64'd0) begin
      return '0;
    end
    p = 0;
    for (int k = 1; k < 64; k++) begin
      if ((r >> k) != 64'd0) begin
        p = k;
      end
    end
    if (p >= 24) begin
      ulp = 64'd1 << (p - 23);
      r   = (r + (ulp >> 1)) & ~(ulp - 64'd1);
    end
    x = real'(r) / TWO_POW_60;
    return SINE_W'($rtoi($sin(x) * 1024.0));
  endfunction

  function automatic sine_half_t sine_half(int unsigned h);
    sine_half_t tab;
    for (int j = 0; j < HALF_ENTRIES; j++) begin
      tab[j] = sine_entry(HALF_ENTRIES * h + j);
    end
    return tab;
  endfunction

  // The table is kept as two halves so that each read is of a 256-entry table.
  localparam sine_half_t SINE_LO = sine_half(0);
  localparam sine_half_t SINE_HI = sine_half(1);

  function automatic ssp_colour_t palette(logic [7:0] idx);
    ssp_colour_t c;
    logic [7:0]  k4;
    k4 = {idx[5:0], 2'b00};
    unique case (idx[7:6])
      PAL_RED_RISE: begin
        c.red   = k4;
        c.green = 8'd254 - k4;
      end
      PAL_GREEN_RISE: begin
        c.red   = 8'd255;
        c.green = k4 + 8'd1;
      end
      PAL_FADE: begin
        c.red   = 8'd254 - k4;
        c.green = 8'd254 - k4;
      end
      PAL_GREEN_ONLY: begin
        c.red   = 8'd0;
        c.green = k4 + 8'd1;
      end
      default: begin
        c.red   = 8'd0;
        c.green = 8'd0;
      end
    endcase
    return c;
  endfunction

endpackage

>>> rtl/core/sine_sum_plasma_pixel_generator.sv
// Top level of the plasma pixel generator: configuration registers and the
// front, queue and back parts. Depends on ssp_pkg, ssp_front, ssp_queue, ssp_back.
//
//   Channel  Direction  Word
//   in       input      frame_start_i: one tick, one pixel
//   out      output     red_o, green_o, blue_o, alpha_o, row_last_o, frame_last_o
//   cfg      input      cfg_index_i, cfg_data_i: one register write
//
// One pixel per clock cycle sustained while the output is not stalled; the front
// updates the raster counters and phases in the cycle of acceptance, so a new tick
// is taken every cycle while in_ready_o is high. A pixel passes from the queue
// via the sine table reads to the lookup stage, then sum and palette to the output.
// Reset clears the raster to the top-left pixel and sets 640 by 480, RGB.
// Output stalls fill the two-stage back pipeline and then the two-word queue
// before in_ready_o falls; cfg_ready_o is always high.
module sine_sum_plasma_pixel_generator #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           frame_start_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o,
  output logic [7:0]                     alpha_o,
  output logic                           row_last_o,
  output logic                           frame_last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ssp_pkg::CFG_W-1:0]      cfg_data_i
);

  ssp_pkg::ssp_cfg_t  cfg_q;
  ssp_pkg::ssp_item_t front_item, queue_item;
  logic               queue_full, queue_valid, queue_pop, push;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= ssp_pkg::CFG_W'(640);
      cfg_q.frame_height <= ssp_pkg::CFG_W'(480);
      cfg_q.alpha_enable <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ssp_pkg::CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i;
        ssp_pkg::CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i;
        ssp_pkg::CFG_ALPHA_ENABLE: cfg_q.alpha_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !queue_full;
  assign push       = in_valid_i && in_ready_o;

  ssp_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .push_i       (push),
    .frame_start_i(frame_start_i),
    .item_o       (front_item)
  );

  ssp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .full_o (queue_full),
    .pop_i  (queue_pop),
    .valid_o(queue_valid),
    .item_o (queue_item)
  );

  ssp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (queue_valid),
    .q_item_i    (queue_item),
    .pop_o       (queue_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .alpha_o     (alpha_o),
    .row_last_o  (row_last_o),
    .frame_last_o(frame_last_o)
  );

  assign blue_o = 8'd0;

endmodule

>>> rtl/core/ssp_front.sv
// Front part: accepts ticks, walks the raster and the phase accumulators.
// Depends on ssp_pkg; feeds one ssp_item_t per accepted word into the queue.
module ssp_front #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssp_pkg::ssp_cfg_t cfg_i,
  input  logic              push_i,
  input  logic              frame_start_i,
  output ssp_pkg::ssp_item_t item_o
);

  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int CNT_W = $clog2(MAX_DIMENSION);
  localparam int CW    = (DIM_W > ssp_pkg::CFG_W) ? DIM_W : ssp_pkg::CFG_W;
  localparam int PW    = ssp_pkg::PHASE_W;
  localparam logic [CW-1:0] MaxDim = CW'(MAX_DIMENSION);

  logic [PW-1:0]    frame_a_q, frame_a_d, frame_c_q, frame_c_d;
  logic [PW-1:0]    row_c_q, row_c_d, row_d_q, row_d_d;
  logic [PW-1:0]    pix_a_q, pix_a_d, pix_b_q, pix_b_d;
  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;

  logic [PW-1:0]    cur_row_c, cur_row_d, cur_pix_a, cur_pix_b;
  logic [CNT_W-1:0] cur_col, cur_row;
  logic [CW-1:0]    width_raw, height_raw, width_eff, height_eff;
  logic             row_end, frame_end;

  assign width_raw  = CW'(cfg_i.frame_width);
  assign height_raw = CW'(cfg_i.frame_height);
  assign width_eff  = (width_raw == '0) ? CW'(1) : ((width_raw > MaxDim) ? MaxDim : width_raw);
  assign height_eff = (height_raw == '0) ? CW'(1) :
                      ((height_raw > MaxDim) ? MaxDim : height_raw);

  always_comb begin
    // A frame start restarts the raster with the current frame phases.
    if (frame_start_i) begin
      cur_row_c = frame_c_q;
      cur_row_d = '0;
      cur_pix_a = frame_a_q + PW'(5);
      cur_pix_b = PW'(3);
      cur_col   = '0;
      cur_row   = '0;
    end else begin
      cur_row_c = row_c_q;
      cur_row_d = row_d_q;
      cur_pix_a = pix_a_q;
      cur_pix_b = pix_b_q;
      cur_col   = col_q;
      cur_row   = row_q;
    end

    row_end   = ((CW + 1)'(cur_col) + (CW + 1)'(1)) >= (CW + 1)'(width_eff);
    frame_end = row_end && (((CW + 1)'(cur_row) + (CW + 1)'(1)) >= (CW + 1)'(height_eff));

    frame_a_d = frame_a_q;
    frame_c_d = frame_c_q;
    row_c_d   = cur_row_c;
    row_d_d   = cur_row_d;
    pix_a_d   = cur_pix_a;
    pix_b_d   = cur_pix_b;
    col_d     = cur_col;
    row_d     = cur_row;
    priority if (!row_end) begin
      col_d   = cur_col + CNT_W'(1);
      pix_a_d = cur_pix_a + PW'(5);
      pix_b_d = cur_pix_b + PW'(3);
    end else if (frame_end) begin
      frame_a_d = frame_a_q + PW'(9);
      frame_c_d = frame_c_q + PW'(8);
      row_c_d   = frame_c_q + PW'(8);
      row_d_d   = '0;
      pix_a_d   = frame_a_q + PW'(14);
      pix_b_d   = PW'(3);
      col_d     = '0;
      row_d     = '0;
    end else begin
      row_d     = cur_row + CNT_W'(1);
      col_d     = '0;
      row_c_d   = cur_row_c + PW'(1);
      row_d_d   = cur_row_d + PW'(3);
      pix_a_d   = frame_a_q + PW'(5);
      pix_b_d   = PW'(3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_a_q <= '0;
      frame_c_q <= '0;
      row_c_q   <= '0;
      row_d_q   <= '0;
      pix_a_q   <= PW'(5);
      pix_b_q   <= PW'(3);
      col_q     <= '0;
      row_q     <= '0;
    end else if (push_i) begin
      frame_a_q <= frame_a_d;
      frame_c_q <= frame_c_d;
      row_c_q   <= row_c_d;
      row_d_q   <= row_d_d;
      pix_a_q   <= pix_a_d;
      pix_b_q   <= pix_b_d;
      col_q     <= col_d;
      row_q     <= row_d;
    end
  end

  assign item_o.phase_a      = cur_pix_a;
  assign item_o.phase_b      = cur_pix_b;
  assign item_o.phase_c      = cur_row_c;
  assign item_o.phase_d      = cur_row_d;
  assign item_o.row_last     = row_end;
  assign item_o.frame_last   = frame_end;
  assign item_o.alpha_enable = cfg_i.alpha_enable;

endmodule

>>> rtl/core/ssp_queue.sv
// Short queue between the front and back parts, two words deep.
// Depends on ssp_pkg for the item type.
module ssp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ssp_pkg::ssp_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output ssp_pkg::ssp_item_t item_o
);

  localparam int PTR_W = $clog2(ssp_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ssp_pkg::QUEUE_DEPTH + 1);

  ssp_pkg::ssp_item_t entry_q [ssp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(ssp_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/ssp_back.sv
// Back part: sine table reads, sum, palette lookup and the output register.
// Depends on ssp_pkg for the sine tables, the palette and the item type.
module ssp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  ssp_pkg::ssp_item_t q_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         alpha_o,
  output logic               row_last_o,
  output logic               frame_last_o
);

  localparam int SW  = ssp_pkg::SINE_W;
  localparam int SUM_W = SW + 2;

  function automatic logic signed [SW-1:0] sine_rd(logic [ssp_pkg::PHASE_W-1:0] ph);
    logic [ssp_pkg::HALF_IDX_W-1:0] low;
    low = ph[ssp_pkg::HALF_IDX_W-1:0];
    return ph[ssp_pkg::PHASE_W-1] ? ssp_pkg::SINE_HI[low] : ssp_pkg::SINE_LO[low];
  endfunction

  logic                 lk_valid_q;
  logic signed [SW-1:0] sin_a_q, sin_b_q, sin_c_q, sin_d_q;
  logic                 lk_row_last_q, lk_frame_last_q, lk_alpha_q;

  logic                 out_valid_q;
  logic [7:0]           red_q, green_q, alpha_q;
  logic                 row_last_q, frame_last_q;

  logic                 adv_out, adv_lk;
  logic signed [SUM_W-1:0] sum;
  logic [7:0]           pal_idx;
  ssp_pkg::ssp_colour_t colour;

  // Each stage moves on when it is empty or the stage after it moves on.
  assign adv_out = !out_valid_q || out_ready_i;
  assign adv_lk  = !lk_valid_q || adv_out;
  assign pop_o   = q_valid_i && adv_lk;

  assign sum = SUM_W'(sin_a_q) + SUM_W'(sin_b_q) + SUM_W'(sin_c_q) + SUM_W'(sin_d_q);
  // The low eight bits of the sum shifted right by four, plus 128.
  assign pal_idx = sum[11:4] + 8'd128;
  assign colour  = ssp_pkg::palette(pal_idx);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sin_a_q         <= sine_rd(q_item_i.phase_a);
      sin_b_q         <= sine_rd(q_item_i.phase_b);
      sin_c_q         <= sine_rd(q_item_i.phase_c);
      sin_d_q         <= sine_rd(q_item_i.phase_d);
      lk_row_last_q   <= q_item_i.row_last;
      lk_frame_last_q <= q_item_i.frame_last;
      lk_alpha_q      <= q_item_i.alpha_enable;
    end
    if (adv_out && lk_valid_q) begin
      red_q        <= colour.red;
      green_q      <= colour.green;
      alpha_q      <= lk_alpha_q ? 8'd255 : 8'd0;
      row_last_q   <= lk_row_last_q;
      frame_last_q <= lk_frame_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_lk) begin
        lk_valid_q <= q_valid_i;
      end
      if (adv_out) begin
        out_valid_q <= lk_valid_q;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign alpha_o      = alpha_q;
  assign row_last_o   = row_last_q;
  assign frame_last_o = frame_last_q;

endmodule

>>> rtl/core/ssp_checker.sv
// Port-level checks for the plasma pixel generator, bound to the top level.
// Depends on the macros header.
`include "sine_sum_plasma_pixel_generator_macros.svh"

module ssp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] alpha_o,
  input logic       row_last_o,
  input logic       frame_last_o
);

  // The last pixel of a frame always closes a row as well.
  `SSP_ASSERT(a_frame_ends_row, out_valid_o && frame_last_o |-> row_last_o)

  `SSP_ASSERT(a_alpha_code, out_valid_o |-> alpha_o == 8'd0 || alpha_o == 8'd255)

  // An odd green byte only comes from the two segments where red is fixed.
  `SSP_ASSERT(a_palette_segment, out_valid_o && green_o[0] |-> red_o == 8'd0 || red_o == 8'd255)

  `SSP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(red_o) && $stable(green_o) && $stable(frame_last_o))

endmodule

bind sine_sum_plasma_pixel_generator ssp_checker u_ssp_checker (.*);
